[rtl/crtc_pkg.sv]
// Shared types, constants and register decode for the CRT controller port.
package crtc_pkg;

   localparam int unsigned NumLanes = 4;
   localparam int unsigned WinBits  = 5;

   localparam logic [WinBits-1:0] OFS_INDEX = 5'h14;
   localparam logic [WinBits-1:0] OFS_DATA  = 5'h15;
   localparam logic [WinBits-1:0] OFS_ALIAS = 5'h13;

   localparam logic [7:0] REG_CUR_START = 8'h0a;
   localparam logic [7:0] REG_CUR_END   = 8'h0b;
   localparam logic [7:0] REG_SA_HI     = 8'h0c;
   localparam logic [7:0] REG_SA_LO     = 8'h0d;
   localparam logic [7:0] REG_LOC_HI    = 8'h0e;
   localparam logic [7:0] REG_LOC_LO    = 8'h0f;

   localparam logic [7:0]  UNCLAIMED_BYTE = 8'hff;
   localparam logic [15:0] IO_BASE_RESET  = 16'h03c0;
   localparam logic [15:0] SHAPE_RESET    = 16'h0d0e;
   localparam logic [15:0] LOC_RESET      = 16'(24 * 80);
   localparam logic [15:0] SA_RESET       = 16'h0000;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_WORD = 2'd1;

   typedef struct packed {
      logic claimed;
      logic is_index;
      logic is_data;
      logic is_alias;
   } lane_hit_type;

   function automatic logic [7:0] crtc_reg_read(
      input logic [7:0]  index,
      input logic [15:0] shape,
      input logic [15:0] loc,
      input logic [15:0] start
   );
      logic [7:0] v;
      unique case (index)
         REG_CUR_START: v = shape[15:8];
         REG_CUR_END:   v = shape[7:0];
         REG_LOC_HI:    v = loc[15:8];
         REG_LOC_LO:    v = loc[7:0];
         REG_SA_HI:     v = start[15:8];
         REG_SA_LO:     v = start[7:0];
         default:       v = UNCLAIMED_BYTE;
      endcase
      return v;
   endfunction

endpackage

[rtl/crtc_if.sv]
// Request and response channel interfaces.
interface crtc_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [15:0] port;
   logic [1:0]  size_code;
   logic [31:0] data;

   modport source (output valid, req_type, port, size_code, data, input ready);
   modport sink   (input valid, req_type, port, size_code, data, output ready);
endinterface

interface crtc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        claimed;

   modport source (output valid, read_data, claimed, input ready);
   modport sink   (input valid, read_data, claimed, output ready);
endinterface

[rtl/crtc_lane.sv]
// Byte lane decoder: window hit and register offset for one lane.
module crtc_lane (
   input  logic [1:0]             lane_num,
   input  logic [15:0]            port,
   input  logic [1:0]             size_code,
   input  logic [15:0]            io_base,
   output crtc_pkg::lane_hit_type hit
);

   logic [15:0] lane_port;
   logic [15:0] ofs;
   logic        in_win;
   logic        active;

   assign lane_port = port + {14'd0, lane_num};
   assign ofs       = lane_port - io_base;
   assign in_win    = (ofs[15:crtc_pkg::WinBits] == '0);

   always_comb begin
      priority if (lane_num == 2'd0) begin
         active = 1'b1;
      end else if (lane_num == 2'd1) begin
         active = (size_code != crtc_pkg::SIZE_BYTE);
      end else begin
         active = (size_code != crtc_pkg::SIZE_BYTE) && (size_code != crtc_pkg::SIZE_WORD);
      end
   end

   always_comb begin
      hit.claimed  = active && in_win;
      hit.is_index = hit.claimed && (ofs[crtc_pkg::WinBits-1:0] == crtc_pkg::OFS_INDEX);
      hit.is_data  = hit.claimed && (ofs[crtc_pkg::WinBits-1:0] == crtc_pkg::OFS_DATA);
      hit.is_alias = hit.claimed && (ofs[crtc_pkg::WinBits-1:0] == crtc_pkg::OFS_ALIAS);
   end

endmodule

[rtl/crtc_merge.sv]
// Lane merge: applies lane writes in order, holds CRT registers, builds read word.
module crtc_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   is_write,
   input  logic [31:0]            data,
   input  crtc_pkg::lane_hit_type hits [crtc_pkg::NumLanes],
   output logic [31:0]            read_data,
   output logic                   claimed
);

   logic [7:0]  crt_index_ff;
   logic [15:0] cursor_shape_ff;
   logic [15:0] cursor_location_ff;
   logic [15:0] start_address_ff;

   logic [7:0]  index_in;
   logic        data_hit;
   logic [7:0]  data_val;
   logic [7:0]  data_idx;
   logic [7:0]  rd_byte;

   assign rd_byte = crtc_pkg::crtc_reg_read(crt_index_ff, cursor_shape_ff,
                                            cursor_location_ff, start_address_ff);

   always_comb begin
      index_in  = crt_index_ff;
      data_hit  = 1'b0;
      data_val  = '0;
      data_idx  = crt_index_ff;
      claimed   = 1'b0;
      read_data = data;
      for (int i = 0; i < crtc_pkg::NumLanes; i++) begin
         claimed = claimed | hits[i].claimed;
         // data lane always follows the index lane, so it sees the running index
         if (hits[i].is_data) begin
            data_hit = 1'b1;
            data_val = data[8*i +: 8];
            data_idx = index_in;
         end
         if (hits[i].is_index) begin
            index_in = data[8*i +: 8];
         end
         if (hits[i].claimed) begin
            priority if (hits[i].is_index) begin
               read_data[8*i +: 8] = crt_index_ff;
            end else if (hits[i].is_data || hits[i].is_alias) begin
               read_data[8*i +: 8] = rd_byte;
            end else begin
               read_data[8*i +: 8] = crtc_pkg::UNCLAIMED_BYTE;
            end
         end
      end
      if (is_write) begin
         read_data = data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crt_index_ff       <= '0;
         cursor_shape_ff    <= crtc_pkg::SHAPE_RESET;
         cursor_location_ff <= crtc_pkg::LOC_RESET;
         start_address_ff   <= crtc_pkg::SA_RESET;
      end else if (accept && is_write) begin
         crt_index_ff <= index_in;
         if (data_hit) begin
            unique case (data_idx)
               crtc_pkg::REG_CUR_START: cursor_shape_ff[15:8]    <= data_val;
               crtc_pkg::REG_CUR_END:   cursor_shape_ff[7:0]     <= data_val;
               crtc_pkg::REG_LOC_HI:    cursor_location_ff[15:8] <= data_val;
               crtc_pkg::REG_LOC_LO:    cursor_location_ff[7:0]  <= data_val;
               crtc_pkg::REG_SA_HI:     start_address_ff[15:8]   <= data_val;
               crtc_pkg::REG_SA_LO:     start_address_ff[7:0]    <= data_val;
               default: ;
            endcase
         end
      end
   end

endmodule

[rtl/vga_crtc_cursor_register_port.sv]
// Top level: CRT controller index/data register port with output skid buffer.
//
// Usage:
//   req_bus carries one I/O access word: req_type (0 read, 1 write), port,
//   size_code (byte, word, dword) and data. Four lane decoders check the
//   byte lanes against the 32-port window at csr io_base in parallel; the
//   merge stage applies lane writes low to high and builds the read word.
//   rsp_bus returns read_data (claimed read lanes replaced) and claimed.
//   Throughput: one access per cycle while req_bus.ready is high, set by the
//   single register update per access. Each result word is registered.
//   Register state changes at the acceptance edge, so the next access sees it.
//   A stalled response holds in the output register; a second word goes to
//   a skid register and req_bus.ready drops only while that skid is full.
//   Reset: synchronous; clears both response valid flags, sets io_base to
//   0x3C0, cursor shape 0x0D0E, cursor location 1920, index and start 0.
//   csr_wr_en writes csr_wr_data to io_base; write only while idle.
module vga_crtc_cursor_register_port (
   input  logic        clock,
   input  logic        reset,
   crtc_req_if.sink    req_bus,
   crtc_rsp_if.source  rsp_bus,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic [15:0] io_base_ff;

   crtc_pkg::lane_hit_type hits [crtc_pkg::NumLanes];

   logic        accept;
   logic [31:0] merged_data;
   logic        merged_claimed;

   logic        out_valid_ff;
   logic [31:0] out_data_ff;
   logic        out_claimed_ff;
   logic        skid_valid_ff;
   logic [31:0] skid_data_ff;
   logic        skid_claimed_ff;
   logic        rsp_fire;

   assign req_bus.ready = !skid_valid_ff;
   assign accept        = req_bus.valid && req_bus.ready;
   assign rsp_fire      = out_valid_ff && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         io_base_ff <= crtc_pkg::IO_BASE_RESET;
      end else if (csr_wr_en) begin
         io_base_ff <= csr_wr_data;
      end
   end

   for (genvar g = 0; g < crtc_pkg::NumLanes; g++) begin : g_lane
      crtc_lane u_lane (
         .lane_num  (2'(g)),
         .port      (req_bus.port),
         .size_code (req_bus.size_code),
         .io_base   (io_base_ff),
         .hit       (hits[g])
      );
   end

   crtc_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .is_write  (req_bus.req_type),
      .data      (req_bus.data),
      .hits      (hits),
      .read_data (merged_data),
      .claimed   (merged_claimed)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_fire) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         if (!out_valid_ff) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire && skid_valid_ff) begin
         out_data_ff    <= skid_data_ff;
         out_claimed_ff <= skid_claimed_ff;
      end else if (accept && (!out_valid_ff || rsp_fire)) begin
         out_data_ff    <= merged_data;
         out_claimed_ff <= merged_claimed;
      end
      if (accept && out_valid_ff && !rsp_fire) begin
         skid_data_ff    <= merged_data;
         skid_claimed_ff <= merged_claimed;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.read_data = out_data_ff;
   assign rsp_bus.claimed   = out_claimed_ff;

endmodule

[rtl/crtc_check.sv]
// Port-level checker for the CRT controller port, bound to the top level.
module crtc_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_type,
   input logic [31:0] req_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_read_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> rsp_valid)
      else $error("accepted word not presented next cycle");

   a_write_echo: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid && req_type |=> rsp_read_data == $past(req_data))
      else $error("write word data not passed through");

endmodule

bind vga_crtc_cursor_register_port crtc_check u_crtc_check (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_type      (req_bus.req_type),
   .req_data      (req_bus.data),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_read_data (rsp_bus.read_data)
);

[sim/tb_vga_crtc_cursor_register_port.sv]
// Testbench for the CRT controller port: directed and random port accesses checked against a shadow model.
module tb_vga_crtc_cursor_register_port;

   localparam logic       ACC_READ   = 1'b0;
   localparam logic       ACC_WRITE  = 1'b1;
   localparam logic [1:0] SIZE_DWORD = 2'd2;
   localparam logic [1:0] SIZE_ODD   = 2'd3;
   localparam logic [15:0] WINDOW_PORTS = 16'(1 << crtc_pkg::WinBits);
   localparam int unsigned RANDOM_PER_PHASE = 165;

   typedef struct packed {
      logic        req_type;
      logic [15:0] port;
      logic [1:0]  size_code;
      logic [31:0] data;
   } bus_access_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        claimed;
   } port_reply_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   crtc_req_if req_bus ();
   crtc_rsp_if rsp_bus ();

   vga_crtc_cursor_register_port dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the register state
   logic [15:0] shadow_base;
   logic [7:0]  shadow_index;
   logic [15:0] shadow_shape;
   logic [15:0] shadow_loc;
   logic [15:0] shadow_start;

   bus_access_type pending_accesses[$];
   port_reply_type expected_replies[$];

   int unsigned req_gap = 0;
   int unsigned rsp_stall = 0;
   bit          req_burst = 0;
   bit          rsp_burst = 0;
   int unsigned reads_sent = 0;
   int unsigned writes_sent = 0;
   int unsigned replies_checked = 0;
   int unsigned replies_claimed = 0;
   int unsigned base_settings = 1;
   int unsigned mismatch_count = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("FAILURE");
      $finish;
   end

   function automatic port_reply_type predict_reply(input bus_access_type a);
      port_reply_type r;
      int unsigned n_lanes;
      int unsigned i;
      logic [15:0] lane_port;
      logic [15:0] ofs;
      logic [7:0]  lane_byte;
      r.read_data = a.data;
      r.claimed   = 1'b0;
      n_lanes = (a.size_code == crtc_pkg::SIZE_BYTE) ? 1 :
                (a.size_code == crtc_pkg::SIZE_WORD) ? 2 : 4;
      for (i = 0; i < n_lanes; i++) begin
         lane_port = a.port + 16'(i);
         ofs = lane_port - shadow_base;
         if (ofs < WINDOW_PORTS) begin
            r.claimed = 1'b1;
            lane_byte = a.data[8*i +: 8];
            if (a.req_type == ACC_WRITE) begin
               if (ofs == 16'(crtc_pkg::OFS_INDEX)) begin
                  shadow_index = lane_byte;
               end else if (ofs == 16'(crtc_pkg::OFS_DATA)) begin
                  case (shadow_index)
                     crtc_pkg::REG_CUR_START: shadow_shape[15:8] = lane_byte;
                     crtc_pkg::REG_CUR_END:   shadow_shape[7:0]  = lane_byte;
                     crtc_pkg::REG_LOC_HI:    shadow_loc[15:8]   = lane_byte;
                     crtc_pkg::REG_LOC_LO:    shadow_loc[7:0]    = lane_byte;
                     crtc_pkg::REG_SA_HI:     shadow_start[15:8] = lane_byte;
                     crtc_pkg::REG_SA_LO:     shadow_start[7:0]  = lane_byte;
                     default: ;
                  endcase
               end
            end else begin
               if (ofs == 16'(crtc_pkg::OFS_INDEX)) begin
                  lane_byte = shadow_index;
               end else if (ofs == 16'(crtc_pkg::OFS_DATA) ||
                            ofs == 16'(crtc_pkg::OFS_ALIAS)) begin
                  case (shadow_index)
                     crtc_pkg::REG_CUR_START: lane_byte = shadow_shape[15:8];
                     crtc_pkg::REG_CUR_END:   lane_byte = shadow_shape[7:0];
                     crtc_pkg::REG_LOC_HI:    lane_byte = shadow_loc[15:8];
                     crtc_pkg::REG_LOC_LO:    lane_byte = shadow_loc[7:0];
                     crtc_pkg::REG_SA_HI:     lane_byte = shadow_start[15:8];
                     crtc_pkg::REG_SA_LO:     lane_byte = shadow_start[7:0];
                     default:                 lane_byte = crtc_pkg::UNCLAIMED_BYTE;
                  endcase
               end else begin
                  lane_byte = crtc_pkg::UNCLAIMED_BYTE;
               end
               r.read_data[8*i +: 8] = lane_byte;
            end
         end
      end
      return r;
   endfunction

   // drives one access word at a time, with a random gap before each
   always @(posedge clock) begin : access_driver
      bus_access_type seen;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            seen = '{req_bus.req_type, req_bus.port, req_bus.size_code, req_bus.data};
            expected_replies.push_back(predict_reply(seen));
            if (seen.req_type == ACC_WRITE) writes_sent++;
            else reads_sent++;
            req_gap = req_burst ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 31) == 0) req_burst = !req_burst;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
               seen = pending_accesses.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.req_type  <= seen.req_type;
               req_bus.port      <= seen.port;
               req_bus.size_code <= seen.size_code;
               req_bus.data      <= seen.data;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // takes reply words with random stalls and checks them in order
   always @(posedge clock) begin : reply_monitor
      port_reply_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: reply with none expected: read_data %h claimed %b",
                        $time, rsp_bus.read_data, rsp_bus.claimed);
               mismatch_count++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_bus.read_data !== want.read_data) begin
                  $display("%0t: read_data mismatch: expected %h actual %h",
                           $time, want.read_data, rsp_bus.read_data);
                  mismatch_count++;
               end
               if (rsp_bus.claimed !== want.claimed) begin
                  $display("%0t: claimed mismatch: expected %b actual %b",
                           $time, want.claimed, rsp_bus.claimed);
                  mismatch_count++;
               end
               if (want.claimed) replies_claimed++;
            end
            replies_checked++;
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 31) == 0) rsp_burst = !rsp_burst;
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic queue_access(input logic rt, input logic [15:0] p,
                               input logic [1:0] sz, input logic [31:0] d);
      pending_accesses.push_back('{rt, p, sz, d});
   endtask

   function automatic logic [7:0] pick_register();
      if ($urandom_range(0, 3) == 0) return 8'($urandom);
      case ($urandom_range(0, 5))
         0: return crtc_pkg::REG_CUR_START;
         1: return crtc_pkg::REG_CUR_END;
         2: return crtc_pkg::REG_LOC_HI;
         3: return crtc_pkg::REG_LOC_LO;
         4: return crtc_pkg::REG_SA_HI;
         default: return crtc_pkg::REG_SA_LO;
      endcase
   endfunction

   // mostly index/data sequences around the window, some pure noise
   function automatic bus_access_type random_access(input logic [15:0] base);
      bus_access_type a;
      a.req_type  = 1'($urandom_range(0, 1));
      a.port      = 16'($urandom);
      a.size_code = 2'($urandom_range(0, 3));
      a.data      = $urandom;
      case ($urandom_range(0, 11))
         0, 1, 2: begin
            a.req_type     = ACC_WRITE;
            a.port         = base + 16'(crtc_pkg::OFS_INDEX);
            a.size_code    = crtc_pkg::SIZE_BYTE;
            a.data[7:0]    = pick_register();
         end
         3, 4: begin
            a.req_type     = ACC_WRITE;
            a.port         = base + 16'(crtc_pkg::OFS_INDEX);
            a.size_code    = crtc_pkg::SIZE_WORD;
            a.data[7:0]    = pick_register();
         end
         5: begin
            a.req_type  = ACC_WRITE;
            a.port      = base + 16'(crtc_pkg::OFS_DATA);
            a.size_code = crtc_pkg::SIZE_BYTE;
         end
         6, 7: begin
            a.req_type = ACC_READ;
            a.port     = base + ($urandom_range(0, 1) ? 16'(crtc_pkg::OFS_DATA)
                                                      : 16'(crtc_pkg::OFS_ALIAS));
         end
         8: a.port = base + 16'($urandom_range(16, 23));
         9: a.port = base + 16'($urandom_range(0, 35)) - 16'd3;
         10: a.port = base + 16'(crtc_pkg::OFS_INDEX) - 16'($urandom_range(0, 3));
         default: ;
      endcase
      return a;
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_accesses.size() != 0 || req_bus.valid || expected_replies.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_io_base(input logic [15:0] base);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= base;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_base = base;
      base_settings++;
   endtask

   initial begin : stimulus
      logic [15:0] phase_bases[6];
      int unsigned p;
      int unsigned n;
      phase_bases = '{16'h0000, 16'hfff0, 16'hffff, 16'h0000, 16'h03b0, 16'h03c0};
      phase_bases[3] = 16'($urandom);
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_bus.valid     = 1'b0;
      req_bus.req_type  = ACC_READ;
      req_bus.port      = '0;
      req_bus.size_code = crtc_pkg::SIZE_BYTE;
      req_bus.data      = '0;
      rsp_bus.ready     = 1'b0;
      shadow_base  = crtc_pkg::IO_BASE_RESET;
      shadow_index = 8'h00;
      shadow_shape = crtc_pkg::SHAPE_RESET;
      shadow_loc   = crtc_pkg::LOC_RESET;
      shadow_start = crtc_pkg::SA_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset values, every register, odd cases, lane straddles and wrap
      queue_access(ACC_READ,  16'h03d4, crtc_pkg::SIZE_BYTE, 32'hffff_ffff);
      queue_access(ACC_READ,  16'h03d2, SIZE_DWORD, 32'h0000_0000);
      queue_access(ACC_WRITE, 16'h03d4, crtc_pkg::SIZE_BYTE, {24'h0, crtc_pkg::REG_CUR_START});
      queue_access(ACC_READ,  16'h03d4, crtc_pkg::SIZE_WORD, 32'h1234_5678);
      queue_access(ACC_WRITE, 16'h03d4, crtc_pkg::SIZE_WORD,
                   {16'h0, 8'h5a, crtc_pkg::REG_CUR_END});
      queue_access(ACC_READ,  16'h03d2, SIZE_ODD,   32'h0000_0000);
      queue_access(ACC_WRITE, 16'h03d4, crtc_pkg::SIZE_WORD,
                   {16'h0, 8'h12, crtc_pkg::REG_LOC_HI});
      queue_access(ACC_READ,  16'h03d3, crtc_pkg::SIZE_WORD, 32'hffff_ffff);
      queue_access(ACC_WRITE, 16'h03d4, crtc_pkg::SIZE_WORD,
                   {16'h0, 8'h34, crtc_pkg::REG_LOC_LO});
      queue_access(ACC_READ,  16'h03d3, SIZE_DWORD, 32'h0000_0000);
      queue_access(ACC_WRITE, 16'h03d4, SIZE_DWORD, {16'habcd, 8'hff, crtc_pkg::REG_SA_HI});
      queue_access(ACC_WRITE, 16'h03d4, crtc_pkg::SIZE_WORD,
                   {16'hffff, 8'h00, crtc_pkg::REG_SA_LO});
      queue_access(ACC_READ,  16'h03d5, crtc_pkg::SIZE_BYTE, 32'h0000_0000);
      queue_access(ACC_WRITE, 16'h03d4, crtc_pkg::SIZE_BYTE, 32'h0000_0055);
      queue_access(ACC_WRITE, 16'h03d5, crtc_pkg::SIZE_BYTE, 32'h0000_0077);
      queue_access(ACC_READ,  16'h03d5, crtc_pkg::SIZE_BYTE, 32'h0000_0000);
      queue_access(ACC_WRITE, 16'h03d4, crtc_pkg::SIZE_BYTE, {24'h0, crtc_pkg::REG_SA_HI});
      queue_access(ACC_WRITE, 16'h03d3, crtc_pkg::SIZE_BYTE, 32'h0000_0099);
      queue_access(ACC_WRITE, 16'h03c0, crtc_pkg::SIZE_BYTE, 32'hffff_ffff);
      queue_access(ACC_READ,  16'h03d5, crtc_pkg::SIZE_BYTE, 32'h0000_0000);
      queue_access(ACC_READ,  16'h0000, crtc_pkg::SIZE_BYTE, 32'hdead_beef);
      queue_access(ACC_READ,  16'h03be, SIZE_DWORD, 32'h0000_0000);
      queue_access(ACC_READ,  16'h03de, SIZE_DWORD, 32'h0000_0000);
      queue_access(ACC_READ,  16'hffff, SIZE_DWORD, 32'hffff_ffff);
      queue_access(ACC_WRITE, 16'hffff, SIZE_DWORD, 32'hffff_ffff);
      for (n = 0; n < RANDOM_PER_PHASE; n++)
         pending_accesses.push_back(random_access(shadow_base));
      wait_drained();

      for (p = 0; p < 6; p++) begin
         set_io_base(phase_bases[p]);
         @(negedge clock);
         for (n = 0; n < RANDOM_PER_PHASE; n++)
            pending_accesses.push_back(random_access(shadow_base));
         wait_drained();
      end

      repeat (10) @(posedge clock);
      $display("Ran %0d reads and %0d writes over %0d window bases, incl. wrap at 0xFFFF.",
               reads_sent, writes_sent, base_settings);
      $display("Checked %0d replies, %0d of them claimed.", replies_checked, replies_claimed);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/crtc_pkg.sv
rtl/crtc_if.sv
rtl/crtc_lane.sv
rtl/crtc_merge.sv
rtl/vga_crtc_cursor_register_port.sv
rtl/crtc_check.sv
sim/tb_vga_crtc_cursor_register_port.sv
